// ===== src/pcbp_pkg.sv =====
// Package for the prefix code bit packer: request and result types, the
// code table entry type, function codes and sizing constants.
// No dependencies.
`default_nettype none

package pcbp_pkg;

  localparam int WORD_BITS         = 32;
  localparam int SYM_BITS          = 8;
  localparam int LEN_BITS          = 6;
  localparam int DEF_MAX_CODE_BITS = 32;
  localparam int DEF_SYMBOL_COUNT  = 256;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_ENCODE = 2'd1,
    FUNC_FLUSH  = 2'd2
  } func_t;

  typedef struct packed {
    logic [1:0]           func;
    logic [SYM_BITS-1:0]  symbol;
    logic [WORD_BITS-1:0] code_value;
    logic [LEN_BITS-1:0]  code_length;
  } in_req_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] packed_word;
    logic                 end_of_run;
    logic                 final_word;
  } out_rsp_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] value;
    logic [LEN_BITS-1:0]  length;
  } code_entry_t;

endpackage

`default_nettype wire

// ===== src/pcbp_stream_if.sv =====
// Valid/ready channel carrying one request or result payload.
// The payload type is set per instance, usually from pcbp_pkg.
`default_nettype none

interface pcbp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/prefix_code_bit_packer_core.sv =====
// Top level of the prefix code bit packer: code table lookup, bit packing
// into 32-bit words and the result register.
// Depends on pcbp_pkg, pcbp_stream_if and pcbp_code_table.
//
//   Channel   Dir  Payload     Meaning
//   in_req    in   in_req_t    load, encode or flush request
//   out_rsp   out  out_rsp_t   completed or flushed 32-bit word
//
// One request per cycle is accepted. The table is read at the edge that accepts
// a request and the request is packed in the following cycle; a word it yields
// then goes to the result register. Loads write the table at acceptance; flushes
// and full words go to a single result register. The input stalls only while the
// packing stage holds a word and the result register is still waiting.
// Reset is synchronous and clears the held word and fill count; the table is
// not cleared.
`default_nettype none

module prefix_code_bit_packer_core
  import pcbp_pkg::*;
#(
  parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS,
  parameter int SYMBOL_COUNT  = DEF_SYMBOL_COUNT
) (
  input  logic          clk,
  input  logic          rst_n,
  pcbp_stream_if.sink   in_req,
  pcbp_stream_if.source out_rsp
);

  localparam int IDX_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int LEN_CAP = (MAX_CODE_BITS < WORD_BITS) ? MAX_CODE_BITS : WORD_BITS;

  in_req_t              req;
  logic                 in_fire;
  logic                 sym_ok;
  logic [LEN_BITS-1:0]  len_capped;
  logic [WORD_BITS:0]   val_mask;
  code_entry_t          wr_entry;
  logic                 wr_en;
  logic                 rd_en;
  code_entry_t          rd_entry;

  logic                 s1_valid_r;
  logic [1:0]           s1_func_r;
  logic                 s1_sym_ok_r;

  logic [WORD_BITS-1:0] held_r;
  logic [WORD_BITS-1:0] held_nxt;
  logic [4:0]           fill_r;
  logic [4:0]           fill_nxt;

  logic                 out_valid_r;
  logic [WORD_BITS-1:0] out_word_r;
  logic                 out_final_r;

  logic [LEN_BITS-1:0]  total;
  logic [LEN_BITS-1:0]  shamt;
  logic [2*WORD_BITS-1:0] acc;
  logic                 wrap;
  logic                 s1_encode;
  logic                 s1_flush;
  logic                 s1_produce;
  logic                 s1_fire;
  logic                 out_free;

  assign req     = in_req.payload;
  assign in_fire = in_req.valid && in_req.ready;
  assign sym_ok  = {1'b0, req.symbol} < (SYM_BITS + 1)'(SYMBOL_COUNT);

  assign len_capped = (req.code_length > LEN_BITS'(LEN_CAP)) ? LEN_BITS'(LEN_CAP)
                                                            : req.code_length;
  assign val_mask        = ((WORD_BITS + 1)'(1) << len_capped) - (WORD_BITS + 1)'(1);
  assign wr_entry.value  = req.code_value & val_mask[WORD_BITS-1:0];
  assign wr_entry.length = len_capped;

  assign wr_en = in_fire && (req.func == FUNC_LOAD) && sym_ok;
  assign rd_en = in_fire && (req.func == FUNC_ENCODE);

  pcbp_code_table #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .IDX_W        (IDX_W)
  ) u_code_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_idx   (req.symbol[IDX_W-1:0]),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_idx   (req.symbol[IDX_W-1:0]),
    .rd_entry (rd_entry)
  );

  // Append the code below the held bits in a 64-bit window.
  assign total = LEN_BITS'(fill_r) + rd_entry.length;
  assign shamt = LEN_BITS'(7'd64 - {1'b0, total});
  assign acc   = {held_r, {WORD_BITS{1'b0}}}
               | ({{WORD_BITS{1'b0}}, rd_entry.value} << shamt);
  assign wrap  = total[LEN_BITS-1];

  assign s1_encode  = s1_valid_r && (s1_func_r == FUNC_ENCODE) && s1_sym_ok_r
                    && (rd_entry.length != '0);
  assign s1_flush   = s1_valid_r && (s1_func_r == FUNC_FLUSH);
  assign s1_produce = s1_flush || (s1_encode && wrap);
  assign out_free   = !out_valid_r || out_rsp.ready;
  assign s1_fire    = s1_valid_r && (!s1_produce || out_free);
  assign in_req.ready = !s1_valid_r || s1_fire;

  always_comb begin
    held_nxt = held_r;
    fill_nxt = fill_r;
    if (s1_flush) begin
      held_nxt = '0;
      fill_nxt = '0;
    end else if (s1_encode) begin
      if (wrap) begin
        held_nxt = acc[WORD_BITS-1:0];
        fill_nxt = 5'(total - LEN_BITS'(WORD_BITS));
      end else begin
        held_nxt = acc[2*WORD_BITS-1:WORD_BITS];
        fill_nxt = total[4:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      held_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        held_r <= held_nxt;
        fill_r <= fill_nxt;
      end
      if (s1_fire && s1_produce) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r   <= req.func;
      s1_sym_ok_r <= sym_ok;
    end
    if (s1_fire && s1_produce) begin
      out_word_r  <= s1_flush ? held_r : acc[2*WORD_BITS-1:WORD_BITS];
      out_final_r <= s1_flush;
    end
  end

  assign out_rsp.valid               = out_valid_r;
  assign out_rsp.payload.packed_word = out_word_r;
  assign out_rsp.payload.end_of_run  = 1'b1;
  assign out_rsp.payload.final_word  = out_final_r;

  // Bits below the held ones are always zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (held_r << fill_r) == '0)
    else $error("held word has bits below the fill point");

  assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_flush |=> (fill_r == '0) && (held_r == '0))
    else $error("flush did not clear the held word");

  assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_produce |=> out_valid_r)
    else $error("produced word did not reach the result register");

  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_produce && !out_free |=> s1_valid_r && $stable(s1_func_r))
    else $error("packing stage moved while the result register was full");

endmodule

`default_nettype wire

// ===== src/pcbp_code_table.sv =====
// Code table memory: one write port and one read port with registered data.
// Depends on pcbp_pkg for the entry type.
`default_nettype none

module pcbp_code_table
  import pcbp_pkg::*;
#(
  parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT,
  parameter int IDX_W        = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  code_entry_t      wr_entry,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output code_entry_t      rd_entry
);

  code_entry_t mem [SYMBOL_COUNT];
  code_entry_t rd_entry_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry_r <= mem[rd_idx];
    end
  end

  assign rd_entry = rd_entry_r;

endmodule

`default_nettype wire

// ===== tb/tb_prefix_code_bit_packer_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for prefix_code_bit_packer_core: directed and random
// load, encode and flush requests checked against an in-bench packing predictor.
// Depends on pcbp_pkg, pcbp_stream_if and the core itself.

module tb_prefix_code_bit_packer_core;
  import pcbp_pkg::*;

  localparam int MAX_BITS     = DEF_MAX_CODE_BITS;
  localparam int SYM_COUNT    = DEF_SYMBOL_COUNT;
  localparam int LEN_CAP      = (MAX_BITS < WORD_BITS) ? MAX_BITS : WORD_BITS;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 400;
  localparam int PRINT_CAP    = 30;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic clk;
  logic rst_n;

  pcbp_stream_if #(.payload_t(in_req_t))  req_if ();
  pcbp_stream_if #(.payload_t(out_rsp_t)) rsp_if ();

  prefix_code_bit_packer_core #(
    .MAX_CODE_BITS(MAX_BITS),
    .SYMBOL_COUNT (SYM_COUNT)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_if),
    .out_rsp(rsp_if)
  );

  code_entry_t        code_tab [SYM_COUNT];
  logic [31:0]        held_word;
  int unsigned        fill_bits;
  out_rsp_t           expected_words [$];

  logic               sym_loaded [SYM_COUNT];
  logic [7:0]         loaded_syms [$];

  int idle_pct;
  int stall_pct;
  int hold_asks;
  int mismatches;
  int words_checked;
  int loads_sent;
  int encodes_sent;
  int flushes_sent;
  int others_sent;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL prefix_code_bit_packer_core");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("ERROR at %0t: %s got %h expected %h", $time, what, got, want);
  endtask

  function automatic void predict_words(input in_req_t r);
    out_rsp_t    w;
    int unsigned clen;
    int unsigned total;
    logic [63:0] mask;
    logic [63:0] acc;
    case (r.func)
      FUNC_LOAD: begin
        if (r.symbol < SYM_COUNT) begin
          clen = (r.code_length > LEN_CAP) ? LEN_CAP : r.code_length;
          mask = (64'd1 << clen) - 64'd1;
          code_tab[r.symbol].length = clen[5:0];
          code_tab[r.symbol].value  = r.code_value & mask[31:0];
        end
      end
      FUNC_ENCODE: begin
        if (r.symbol < SYM_COUNT && code_tab[r.symbol].length != 0) begin
          total = fill_bits + code_tab[r.symbol].length;
          acc = {held_word, 32'd0} | (64'(code_tab[r.symbol].value) << (64 - total));
          if (total >= WORD_BITS) begin
            w.packed_word = acc[63:32];
            w.end_of_run  = 1'b1;
            w.final_word  = 1'b0;
            expected_words.push_back(w);
            held_word = acc[31:0];
            fill_bits = total - WORD_BITS;
          end else begin
            held_word = acc[63:32];
            fill_bits = total;
          end
        end
      end
      FUNC_FLUSH: begin
        w.packed_word = held_word;
        w.end_of_run  = 1'b1;
        w.final_word  = 1'b1;
        expected_words.push_back(w);
        held_word = '0;
        fill_bits = 0;
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin : check_words
    out_rsp_t want;
    if (rst_n && req_if.valid && req_if.ready)
      predict_words(req_if.payload);
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected result word", rsp_if.payload.packed_word, '0);
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (rsp_if.payload.packed_word !== want.packed_word)
          report_mismatch("packed_word", rsp_if.payload.packed_word, want.packed_word);
        if (rsp_if.payload.end_of_run !== want.end_of_run)
          report_mismatch("end_of_run", 32'(rsp_if.payload.end_of_run),
                          32'(want.end_of_run));
        if (rsp_if.payload.final_word !== want.final_word)
          report_mismatch("final_word", 32'(rsp_if.payload.final_word),
                          32'(want.final_word));
      end
    end
  end

  // The receiver stalls at random, or holds off completely while a hold is pending.
  initial begin : receiver
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  function automatic in_req_t mk_req(input logic [1:0] f, input logic [7:0] s,
                                     input logic [31:0] v, input logic [5:0] l);
    in_req_t r;
    r.func        = f;
    r.symbol      = s;
    r.code_value  = v;
    r.code_length = l;
    return r;
  endfunction

  task automatic send_req(input in_req_t r);
    logic [63:0] noise;
    while ($urandom_range(0, 99) < idle_pct) begin
      noise = {$urandom(), $urandom()};
      req_if.valid   <= 1'b0;
      req_if.payload <= noise[47:0];
      @(negedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
    case (r.func)
      FUNC_LOAD: begin
        loads_sent++;
        if (!sym_loaded[r.symbol]) begin
          sym_loaded[r.symbol] = 1'b1;
          loaded_syms.push_back(r.symbol);
        end
      end
      FUNC_ENCODE: encodes_sent++;
      FUNC_FLUSH:  flushes_sent++;
      default:     others_sent++;
    endcase
  endtask

  function automatic in_req_t random_load();
    int          pick;
    logic [5:0]  len;
    pick = $urandom_range(0, 99);
    if (pick < 5)       len = 6'd0;
    else if (pick < 12) len = 6'($urandom_range(33, 63));
    else if (pick < 20) len = 6'd32;
    else if (pick < 60) len = 6'($urandom_range(1, 12));
    else                len = 6'($urandom_range(13, 31));
    return mk_req(FUNC_LOAD, 8'($urandom_range(0, 255)), $urandom(), len);
  endfunction

  function automatic in_req_t pick_encode();
    logic [7:0] s;
    if (loaded_syms.size() == 0)
      return random_load();
    s = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
    return mk_req(FUNC_ENCODE, s, $urandom(), 6'($urandom_range(0, 63)));
  endfunction

  function automatic in_req_t random_req();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 12)
      return random_load();
    if (pick < 18)
      return mk_req(FUNC_FLUSH, 8'($urandom_range(0, 255)), $urandom(),
                    6'($urandom_range(0, 63)));
    if (pick < 21)
      return mk_req(FUNC_UNUSED, 8'($urandom_range(0, 255)), $urandom(),
                    6'($urandom_range(0, 63)));
    return pick_encode();
  endfunction

  task automatic test_table_loads();
    send_req(mk_req(FUNC_LOAD, 8'd0,   32'h0000_0001, 6'd1));
    send_req(mk_req(FUNC_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd32));
    send_req(mk_req(FUNC_LOAD, 8'd1,   32'hFFFF_FFFF, 6'd0));
    send_req(mk_req(FUNC_LOAD, 8'd2,   32'hDEAD_BEEF, 6'd63));
    send_req(mk_req(FUNC_LOAD, 8'd3,   32'hFFFF_FFE5, 6'd5));
    send_req(mk_req(FUNC_LOAD, 8'd128, 32'h2AAA_AAAA, 6'd31));
  endtask

  task automatic test_flush_empty();
    send_req(mk_req(FUNC_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F));
  endtask

  task automatic test_word_boundaries();
    send_req(mk_req(FUNC_ENCODE, 8'd0,   32'd0, 6'd0));
    send_req(mk_req(FUNC_ENCODE, 8'd255, 32'd0, 6'd0));
    send_req(mk_req(FUNC_ENCODE, 8'd1,   32'd0, 6'd0));
    send_req(mk_req(FUNC_ENCODE, 8'd2,   32'd0, 6'd0));
    send_req(mk_req(FUNC_ENCODE, 8'd3,   32'd0, 6'd0));
    send_req(mk_req(FUNC_ENCODE, 8'd128, 32'd0, 6'd0));
    send_req(mk_req(FUNC_FLUSH,  8'd0,   32'd0, 6'd0));
  endtask

  task automatic test_unused_func();
    send_req(mk_req(FUNC_ENCODE, 8'd3,   32'd0,         6'd0));
    send_req(mk_req(FUNC_UNUSED, 8'hFF,  32'hFFFF_FFFF, 6'h3F));
    send_req(mk_req(FUNC_UNUSED, 8'h00,  32'h0000_0000, 6'h00));
    send_req(mk_req(FUNC_FLUSH,  8'd0,   32'd0,         6'd0));
  endtask

  task automatic test_exact_word();
    send_req(mk_req(FUNC_ENCODE, 8'd255, 32'd0, 6'd0));
    send_req(mk_req(FUNC_ENCODE, 8'd2,   32'd0, 6'd0));
    send_req(mk_req(FUNC_FLUSH,  8'd0,   32'd0, 6'd0));
  endtask

  task automatic test_random_stream(input int n, input int sender_idle,
                                    input int receiver_stall);
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    repeat (n) send_req(random_req());
  endtask

  task automatic test_output_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    hold_asks++;
    repeat (120) send_req(pick_encode());
  endtask

  initial begin
    rst_n          = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    held_word      = '0;
    fill_bits      = 0;
    idle_pct       = 0;
    stall_pct      = 0;
    hold_asks      = 0;
    mismatches     = 0;
    words_checked  = 0;
    loads_sent     = 0;
    encodes_sent   = 0;
    flushes_sent   = 0;
    others_sent    = 0;
    cycle_count    = 0;
    foreach (sym_loaded[i]) sym_loaded[i] = 1'b0;
    foreach (code_tab[i]) code_tab[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_table_loads();
    test_flush_empty();
    test_word_boundaries();
    test_unused_func();
    test_exact_word();
    test_random_stream(220, 0, 0);
    test_random_stream(220, 68, 0);
    test_random_stream(220, 0, 68);
    test_random_stream(220, 37, 37);
    test_output_backpressure();

    req_if.valid <= 1'b0;
    stall_pct = 0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d loads, %0d encodes, %0d flushes and %0d unused requests.",
             loads_sent, encodes_sent, flushes_sent, others_sent);
    $display("Checked %0d words over four idle mixes and one long receiver hold.",
             words_checked);
    if (mismatches == 0) begin
      $display("PASS prefix_code_bit_packer_core");
    end else begin
      $display("FAIL prefix_code_bit_packer_core");
    end
    $finish;
  end

endmodule
